@@ hw/rtl/p2rf_pkg.sv @@
`default_nettype none
package p2rf_pkg;

	// channel encodings
	localparam logic [1:0] KIND_F32 = 2'd0;
	localparam logic [1:0] KIND_F16 = 2'd1;
	localparam logic [1:0] KIND_U8  = 2'd2;
	localparam logic [1:0] KIND_U16 = 2'd3;

	localparam logic [4:0]  FMT_RESET = 5'd1;
	localparam logic [31:0] ONE_F32   = 32'h3F80_0000;
	localparam int unsigned NUM_LANES = 4;

	typedef logic [31:0] word_t;

	typedef struct packed {
		word_t chan0;
		word_t chan1;
		word_t chan2;
		word_t chan3;
	} pix_in_t;

	typedef struct packed {
		word_t red_out;
		word_t green_out;
		word_t blue_out;
		word_t alpha_out;
	} pix_out_t;

endpackage
`default_nettype wire

@@ hw/rtl/p2rf_lane.sv @@
`default_nettype none
module p2rf_lane (
	input  wire logic          clk,
	input  wire logic [1:0]    kind,
	input  wire p2rf_pkg::word_t raw,
	output p2rf_pkg::word_t    res_s1
);
	import p2rf_pkg::*;

	logic [15:0] v16;
	logic [7:0]  v8;
	logic [4:0]  lz16;
	logic [3:0]  lz8;
	logic [31:0] rot16_w;
	logic [15:0] rot8_w;
	logic [31:0] stream;
	logic [24:0] q;
	logic [7:0]  ex_u;
	logic [3:0]  lzu;
	word_t       unorm;
	word_t       half;
	word_t       res;
	logic [4:0]  h_ex;
	logic [9:0]  h_man;
	logic [3:0]  h_k;
	logic [19:0] h_shift;
	logic [7:0]  h_e;

	// unorm: v/(2^p-1) is v repeated forever, never an exact tie
	always_comb begin
		v16 = raw[15:0];
		v8  = raw[7:0];
		lz16 = 5'd0;
		for (int i = 0; i < 16; i++) begin
			if (v16[i]) lz16 = 5'(15 - i);
		end
		lz8 = 4'd0;
		for (int i = 0; i < 8; i++) begin
			if (v8[i]) lz8 = 4'(7 - i);
		end
		rot16_w = {v16, v16} << lz16;
		rot8_w  = {v8, v8} << lz8;
		if (kind == KIND_U8) begin
			stream = {rot8_w[15:8], rot8_w[15:8], rot8_w[15:8], rot8_w[15:8]};
			lzu    = lz8;
		end else begin
			stream = {rot16_w[31:16], rot16_w[31:16]};
			lzu    = lz16[3:0];
		end
		q    = {1'b0, stream[31:8]} + {24'd0, stream[7]};
		ex_u = 8'd126 - {4'd0, lzu};
		if ((kind == KIND_U8 && v8 == 8'd0) || (kind != KIND_U8 && v16 == 16'd0)) begin
			unorm = 32'd0;
		end else if ((kind == KIND_U8 && v8 == 8'hFF) ||
			(kind != KIND_U8 && v16 == 16'hFFFF)) begin
			unorm = ONE_F32;
		end else begin
			unorm = {1'b0, ex_u, q[22:0]};
		end
	end

	// half widening, subnormals normalised by leading-one search
	always_comb begin
		h_ex  = raw[14:10];
		h_man = raw[9:0];
		h_k   = 4'd0;
		for (int i = 0; i < 10; i++) begin
			if (h_man[i]) h_k = 4'(10 - i);
		end
		h_shift = {10'd0, h_man} << h_k;
		h_e     = 8'd113 - {4'd0, h_k};
		if (h_ex == 5'h1F) begin
			half = {raw[15], 8'hFF, h_man, 13'd0};
		end else if (h_ex != 5'd0) begin
			half = {raw[15], 3'd0, h_ex, 23'd0} + {1'b0, 8'd112, 23'd0} + {9'd0, h_man, 13'd0};
		end else if (h_man == 10'd0) begin
			half = {raw[15], 31'd0};
		end else begin
			half = {raw[15], h_e, h_shift[9:0], 13'd0};
		end
	end

	// kind select
	always_comb begin
		case (kind)
			KIND_F32: res = raw;
			KIND_F16: res = half;
			default:  res = unorm;
		endcase
	end

	// lane result register
	always_ff @(posedge clk) begin
		res_s1 <= res;
	end

endmodule
`default_nettype wire

@@ hw/rtl/p2rf_merge.sv @@
`default_nettype none
module p2rf_merge (
	input  wire logic              clk,
	input  wire logic [4:0]        fmt_s1,
	input  wire p2rf_pkg::word_t   lane0_s1,
	input  wire p2rf_pkg::word_t   lane1_s1,
	input  wire p2rf_pkg::word_t   lane2_s1,
	input  wire p2rf_pkg::word_t   lane3_s1,
	output p2rf_pkg::pix_out_t     res_q
);
	import p2rf_pkg::*;

	pix_out_t res_d;

	// route lanes by format: luminance fans out, missing alpha is one
	always_comb begin
		res_d.red_out   = 32'd0;
		res_d.green_out = 32'd0;
		res_d.blue_out  = 32'd0;
		res_d.alpha_out = ONE_F32;
		if (!fmt_s1[4]) begin
			if (fmt_s1[3]) begin
				res_d.red_out   = lane0_s1;
				res_d.green_out = lane0_s1;
				res_d.blue_out  = lane0_s1;
				if (fmt_s1[0]) res_d.alpha_out = lane1_s1;
			end else begin
				res_d.red_out   = lane0_s1;
				res_d.green_out = lane1_s1;
				res_d.blue_out  = lane2_s1;
				if (fmt_s1[0]) res_d.alpha_out = lane3_s1;
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		res_q <= res_d;
	end

endmodule
`default_nettype wire

@@ hw/rtl/pixel_to_rgba_float_top.sv @@
`default_nettype none
// channel   signals             width  notes
// command   start, busy, pixel  128    taken when start and not busy
// result    done, result        128    valid for one cycle while done high
// config    wr_en, wr_data      5      pixel format, written at once
//
// one pixel per clock; busy is never raised
// the result passes the lane conversion register, then the merge register
// reset clears the format to 1 and drops pending strobes
// the receiver cannot stall: each result shows for exactly one cycle
module pixel_to_rgba_float_top (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire p2rf_pkg::pix_in_t   pixel,
	output logic                     done,
	output p2rf_pkg::pix_out_t       result,
	input  wire logic                wr_en,
	input  wire logic [4:0]          wr_data
);
	import p2rf_pkg::*;

	logic [4:0] fmt_q;
	logic [4:0] fmt_s1;
	logic       vld_s1;
	logic       vld_s2;
	word_t      lane_s1 [NUM_LANES];
	word_t      lane_in [NUM_LANES];

	assign busy = 1'b0;

	// format register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= FMT_RESET;
		end else if (wr_en) begin
			fmt_q <= wr_data;
		end
	end

	// transaction valid pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		fmt_s1 <= fmt_q;
	end

	assign lane_in[0] = pixel.chan0;
	assign lane_in[1] = pixel.chan1;
	assign lane_in[2] = pixel.chan2;
	assign lane_in[3] = pixel.chan3;

	// one conversion lane per channel
	for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
		p2rf_lane u_lane (
			.clk    (clk),
			.kind   (fmt_q[2:1]),
			.raw    (lane_in[g]),
			.res_s1 (lane_s1[g])
		);
	end

	p2rf_merge u_merge (
		.clk      (clk),
		.fmt_s1   (fmt_s1),
		.lane0_s1 (lane_s1[0]),
		.lane1_s1 (lane_s1[1]),
		.lane2_s1 (lane_s1[2]),
		.lane3_s1 (lane_s1[3]),
		.res_q    (result)
	);

	assign done = vld_s2;

endmodule
`default_nettype wire
